### hw/rtl/wheel_speed_capture_filter_defines.svh
// Assertion macros used by the FIFO.
`ifndef WHEEL_SPEED_CAPTURE_FILTER_DEFINES_SVH
`define WHEEL_SPEED_CAPTURE_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

### hw/rtl/wsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsc_pkg;

  localparam int CAP_W           = 16;
  localparam int SPD_W           = 8;
  localparam int NUM_W           = 28;   // 900000 * 255 fits
  localparam int DEN_W           = 40;   // pulses * turns * period
  localparam int STEP_W          = 5;
  localparam int NUM_SCALE       = 900000; // 3600 * 1000 / 4
  localparam int STORE_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSES = 3'd0,
    CFG_TURNS  = 3'd1,
    CFG_TICK   = 3'd2,
    CFG_BAND1  = 3'd3,
    CFG_BAND2  = 3'd4,
    CFG_BAND3  = 3'd5,
    CFG_WINDOW = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_DROP_MAX  = 2'd0,
    MODE_DROP_BOTH = 2'd1,
    MODE_AVG_N     = 2'd2
  } mean_mode_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_SPD,
    BK_SPD_WAIT,
    BK_CLASS,
    BK_SCAN,
    BK_MEAN,
    BK_MEAN_WAIT,
    BK_FILTER
  } bk_state_t;

  typedef struct packed {
    logic [7:0]  pulses_per_turn;
    logic [15:0] turns_per_km;
    logic [7:0]  tick_scale;
    logic [7:0]  band1_limit;
    logic [7:0]  band2_limit;
    logic [7:0]  band3_limit;
    logic [31:0] window_sizes;
  } cfg_t;

  typedef struct packed {
    logic              second;
    logic [CAP_W-1:0]  period;
  } q_entry_t;

endpackage
`default_nettype wire

### hw/rtl/wsc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wsc_front
  import wsc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CAP_W-1:0] in_capture_value,
  input  wire logic             q_full,
  output logic                  q_push,
  output q_entry_t              q_wdata
);

  logic             phase_r;
  logic [CAP_W-1:0] start_r;
  logic [CAP_W:0]   wrap_sum;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // equal captures wrap to a full count
  assign wrap_sum = {1'b0, 16'hffff} + {1'b0, in_capture_value} - {1'b0, start_r};

  always_comb begin
    q_wdata.second = phase_r;
    if (in_capture_value > start_r) begin
      q_wdata.period = in_capture_value - start_r;
    end else begin
      q_wdata.period = wrap_sum[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      start_r <= '0;
    end else if (q_push) begin
      phase_r <= !phase_r;
      if (!phase_r) begin
        start_r <= in_capture_value;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/wsc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "wheel_speed_capture_filter_defines.svh"
module wsc_fifo
  import wsc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  q_entry_t      wdata,
  input  wire logic     pop,
  output q_entry_t      rdata,
  output logic          full,
  output logic          not_empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t        ent_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full      = (cnt_r == CW'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, not_empty)
  `ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule
`default_nettype wire

### hw/rtl/wsc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module wsc_div
  import wsc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [STEP_W-1:0] steps,
  input  wire logic [NUM_W-1:0]  dividend,
  input  wire logic [DEN_W-1:0]  divisor,
  output logic                   done,
  output logic [SPD_W-1:0]       quotient
);

  // restoring division, one quotient bit per cycle from the top of dividend
  logic [DEN_W:0]      rem_r;
  logic [NUM_W-1:0]    dvd_r;
  logic [DEN_W-1:0]    dvs_r;
  logic [SPD_W-1:0]    q_r;
  logic [STEP_W-1:0]   cnt_r;
  logic                busy_r, done_r;
  logic [DEN_W:0]      rem_sh;
  logic                qbit;

  assign rem_sh   = {rem_r[DEN_W-1:0], dvd_r[NUM_W-1]};
  assign qbit     = (rem_sh >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? rem_sh - {1'b0, dvs_r} : rem_sh;
      dvd_r <= {dvd_r[NUM_W-2:0], 1'b0};
      q_r   <= {q_r[SPD_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/wsc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module wsc_back
  import wsc_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  cfg_t                  cfg,
  input  wire logic             q_valid,
  input  q_entry_t              q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_speed_updated,
  output logic [SPD_W-1:0]      out_speed_kmh
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int SW = SPD_W + CW;

  bk_state_t st_r, st_nxt;

  logic [SPD_W-1:0] mem [STORE_DEPTH];
  logic [SPD_W-1:0] rd_data_r;

  logic [CAP_W-1:0] period_r;
  logic [NUM_W-1:0] num_r;
  logic [23:0]      prod1_r;
  logic [DEN_W-1:0] dvs_r;
  logic [SPD_W-1:0] speed_r;
  mean_mode_t       mode_r;
  logic [CW-1:0]    n_r, k_r, count_r;
  logic [SW-1:0]    sum_r;
  logic [SPD_W-1:0] mx_r, mn_r, cand_r;
  logic [SPD_W-1:0] published_r, last_r;
  logic [1:0]       low_r, jump_r;
  logic             out_valid_r, out_upd_r;
  logic [SPD_W-1:0] out_spd_r;

  logic             out_free;
  logic             div_start, div_done;
  logic [STEP_W-1:0] div_steps;
  logic [NUM_W-1:0] div_dvd;
  logic [DEN_W-1:0] div_dvs;
  logic [SPD_W-1:0] div_q;

  // classification of the fresh speed
  logic [AW-1:0]    idx;
  logic [CW-1:0]    idx_p1;
  logic             slow, full;
  logic [15:0]      tens_prod;
  logic [4:0]       tens;
  logic [2:0]       slot;
  logic [3:0]       nib;
  logic [4:0]       nb;
  logic [CW-1:0]    n_sel;
  mean_mode_t       mode_sel;

  // mean and spike filter
  logic [SW-1:0]    trim;
  logic [SPD_W:0]   last_p5, last_p10;
  logic [SPD_W-1:0] cand_f;
  logic [1:0]       low_n, jump_n;

  assign out_free          = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_speed_updated = out_upd_r;
  assign out_speed_kmh     = out_spd_r;

  always_comb begin
    idx    = (count_r >= CW'(STORE_DEPTH)) ? AW'(STORE_DEPTH - 1) : count_r[AW-1:0];
    idx_p1 = CW'(idx) + 1'b1;
    slow   = speed_r < cfg.band1_limit;
    tens_prod = 16'(speed_r) * 16'd205;
    tens   = tens_prod[15:11];
    if (speed_r < cfg.band2_limit) begin
      slot = 3'd0; mode_sel = MODE_DROP_MAX;
    end else if (speed_r < cfg.band3_limit) begin
      slot = 3'd1; mode_sel = MODE_DROP_BOTH;
    end else begin
      mode_sel = MODE_AVG_N;
      if (tens == 5'd2) slot = 3'd2;
      else if (tens == 5'd3 || tens == 5'd4) slot = 3'd3;
      else if (tens == 5'd5 || tens == 5'd6) slot = 3'd4;
      else if (tens == 5'd7 || tens == 5'd8) slot = 3'd5;
      else if (tens == 5'd9 || tens == 5'd10) slot = 3'd6;
      else slot = 3'd7;
    end
    nib = cfg.window_sizes[{slot, 2'b00} +: 4];
    nb  = {1'b0, nib};
    if (nb < 5'd3) nb = 5'd3;
    if (nb > 5'(STORE_DEPTH)) nb = 5'(STORE_DEPTH);
    n_sel = CW'(nb);
    full  = idx_p1 >= n_sel;
  end

  always_comb begin
    if (mode_r == MODE_DROP_MAX) begin
      trim = sum_r - SW'(mx_r);
    end else begin
      trim = sum_r - SW'(mx_r) - SW'(mn_r);
    end
  end

  always_comb begin
    last_p5  = {1'b0, last_r} + 9'd5;
    last_p10 = {1'b0, last_r} + 9'd10;
    cand_f   = cand_r;
    low_n    = low_r;
    jump_n   = jump_r;
    if ({1'b0, cand_r} > last_p5 && last_r < 8'd2) begin
      low_n = (low_r == 2'd3) ? low_r : low_r + 1'b1;
      if (low_n < 2'd2) cand_f = last_r;
    end else if ({1'b0, cand_r} > last_p10) begin
      jump_n = (jump_r == 2'd3) ? jump_r : jump_r + 1'b1;
      if (jump_n < 2'd3) cand_f = last_r;
    end else begin
      low_n  = 2'd0;
      jump_n = 2'd0;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE:      if (q_valid && out_free && q_data.second) st_nxt = BK_MUL1;
      BK_MUL1:      st_nxt = BK_MUL2;
      BK_MUL2:      st_nxt = BK_SPD;
      BK_SPD:       st_nxt = (dvs_r == '0) ? BK_CLASS : BK_SPD_WAIT;
      BK_SPD_WAIT:  if (div_done) st_nxt = BK_CLASS;
      BK_CLASS: begin
        if (slow) st_nxt = BK_FILTER;
        else if (full) st_nxt = BK_SCAN;
        else st_nxt = BK_IDLE;
      end
      BK_SCAN:      if (k_r == n_r) st_nxt = BK_MEAN;
      // halving is a shift, only the n-2 mean needs the divider
      BK_MEAN:      st_nxt = (mode_r == MODE_AVG_N) ? BK_MEAN_WAIT : BK_FILTER;
      BK_MEAN_WAIT: if (div_done) st_nxt = BK_FILTER;
      BK_FILTER:    st_nxt = BK_IDLE;
      default:      st_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = (st_r == BK_IDLE) && q_valid && out_free;
    div_start = ((st_r == BK_SPD) && (dvs_r != '0)) ||
                ((st_r == BK_MEAN) && (mode_r == MODE_AVG_N));
    if (st_r == BK_MEAN) begin
      div_steps = STEP_W'(SW);
      div_dvd   = {trim, {(NUM_W - SW){1'b0}}};
      div_dvs   = DEN_W'(n_r - CW'(2));
    end else begin
      div_steps = STEP_W'(NUM_W);
      div_dvd   = num_r;
      div_dvs   = dvs_r;
    end
  end

  wsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .steps    (div_steps),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (st_r == BK_CLASS) begin
      mem[idx] <= speed_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[k_r[AW-1:0]];
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (q_pop) period_r <= q_data.period;
    if (st_r == BK_MUL1) begin
      num_r   <= NUM_W'(NUM_SCALE) * NUM_W'(cfg.tick_scale);
      prod1_r <= 24'(cfg.pulses_per_turn) * 24'(cfg.turns_per_km);
    end
    if (st_r == BK_MUL2) dvs_r <= DEN_W'(prod1_r) * DEN_W'(period_r);
    if (st_r == BK_SPD && dvs_r == '0) speed_r <= 8'd255;
    if (st_r == BK_SPD_WAIT && div_done) speed_r <= div_q;
    if (st_r == BK_CLASS) begin
      cand_r <= speed_r;
      mode_r <= mode_sel;
      n_r    <= n_sel;
      k_r    <= '0;
      sum_r  <= '0;
    end
    if (st_r == BK_SCAN) begin
      // read of k issued now, data of k-1 arrives now
      if (k_r != n_r) k_r <= k_r + 1'b1;
      if (k_r != '0) begin
        sum_r <= sum_r + SW'(rd_data_r);
        if (k_r == CW'(1) || rd_data_r > mx_r) mx_r <= rd_data_r;
        if (k_r == CW'(1) || rd_data_r < mn_r) mn_r <= rd_data_r;
      end
    end
    if (st_r == BK_MEAN && mode_r != MODE_AVG_N) cand_r <= trim[SPD_W:1];
    if (st_r == BK_MEAN_WAIT && div_done) cand_r <= div_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
      out_upd_r   <= 1'b0;
      out_spd_r   <= '0;
      published_r <= '0;
      last_r      <= '0;
      low_r       <= '0;
      jump_r      <= '0;
      count_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_ready) out_valid_r <= 1'b0;
      if (q_pop && !q_data.second) begin
        out_valid_r <= 1'b1;
        out_upd_r   <= 1'b0;
        out_spd_r   <= published_r;
      end
      if (st_r == BK_CLASS) begin
        count_r <= idx_p1;
        if (!slow && !full) begin
          out_valid_r <= 1'b1;
          out_upd_r   <= 1'b0;
          out_spd_r   <= published_r;
        end
      end
      if (st_r == BK_FILTER) begin
        count_r     <= '0;
        low_r       <= low_n;
        jump_r      <= jump_n;
        last_r      <= cand_f;
        published_r <= cand_f;
        out_valid_r <= 1'b1;
        out_upd_r   <= 1'b1;
        out_spd_r   <= cand_f;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/wheel_speed_capture_filter.sv
// One capture word at a time. First capture of a pair: out_valid is registered when the back
// end pops it from the queue. Second capture: MUL1, MUL2, a 28-step speed divider (skipped
// with a zero divisor), then classify. A full window adds a scan and a halving, or a scan
// and a 13-step divide by n-2. The back end takes the next word once idle with its output
// register free; a two-word queue takes new captures meanwhile.
// Synchronous active-low reset restores default config registers and clears the control state.
`timescale 1ns / 1ps
`default_nettype none
module wheel_speed_capture_filter
  import wsc_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CAP_W-1:0]      in_capture_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_speed_updated,
  output logic [SPD_W-1:0]           out_speed_kmh,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r;
  q_entry_t q_wdata, q_rdata;
  logic     q_push, q_pop, q_full, q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulses_per_turn <= 8'd4;
      cfg_r.turns_per_km    <= 16'd1000;
      cfg_r.tick_scale      <= 8'd32;
      cfg_r.band1_limit     <= 8'd10;
      cfg_r.band2_limit     <= 8'd15;
      cfg_r.band3_limit     <= 8'd20;
      cfg_r.window_sizes    <= 32'h8888_6643;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PULSES: cfg_r.pulses_per_turn <= cfg_data[7:0];
        CFG_TURNS:  cfg_r.turns_per_km    <= cfg_data[15:0];
        CFG_TICK:   cfg_r.tick_scale      <= cfg_data[7:0];
        CFG_BAND1:  cfg_r.band1_limit     <= cfg_data[7:0];
        CFG_BAND2:  cfg_r.band2_limit     <= cfg_data[7:0];
        CFG_BAND3:  cfg_r.band3_limit     <= cfg_data[7:0];
        CFG_WINDOW: cfg_r.window_sizes    <= cfg_data;
        default: ;
      endcase
    end
  end

  wsc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_capture_value (in_capture_value),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  wsc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_valid)
  );

  wsc_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_data            (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_speed_updated (out_speed_updated),
    .out_speed_kmh     (out_speed_kmh)
  );

endmodule
`default_nettype wire
